// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/dicn_pkg.sv =====
package dicn_pkg;

  localparam int NEWTON_STEPS  = 8;
  localparam int FRACTION_BITS = 16;
  localparam int PROB_W        = 16;
  localparam int RADIUS_W      = 24;
  localparam int TAYLOR_TERMS  = 13;

  localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;
  localparam logic [31:0]         LN2_Q32    = 32'hB17217F8;

  // State of one item between Newton steps.
  typedef struct packed {
    logic [RADIUS_W-1:0]      x;
    logic [FRACTION_BITS-1:0] xi;
    logic                     flag;
  } item_t;

endpackage

// ===== rtl/core/dicn_step.sv =====
module dicn_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            ce,
  input  logic            in_valid,
  input  dicn_pkg::item_t in_item,
  output logic            out_valid,
  output dicn_pkg::item_t out_item
);
  import dicn_pkg::*;

  localparam int F          = FRACTION_BITS;
  localparam int TS         = 4 * (TAYLOR_TERMS - 1);
  localparam int DIV_STEP   = 4;
  localparam int NUM_W      = F + 17;
  localparam int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int QW         = DIV_STAGES * DIV_STEP;
  localparam int E4J        = 6 + TS + 4;
  localparam int DEPTH      = E4J + DIV_STAGES + 1;

  localparam logic [31:0] RECIP3    = 32'((64'd1 << 32) / 3);
  localparam logic [16:0] RECIP_LN2 = 17'((64'd1 << 48) / LN2_Q32);

  typedef struct packed {
    logic [31:0] r;
    logic [8:0]  n;
    logic [33:0] pos;
    logic [33:0] neg;
  } acc_t;

  typedef struct packed {
    logic [QW-1:0] num;
    logic [QW-1:0] quo;
    logic [F:0]    rem;
    logic [F-1:0]  d;
    logic          fneg;
    logic          dz;
  } div_t;

  function automatic div_t div_next(input div_t a);
    div_t o;
    o = a;
    for (int i = 0; i < DIV_STEP; i++) begin
      o.rem = {o.rem[F-1:0], o.num[QW-1]};
      o.num = {o.num[QW-2:0], 1'b0};
      o.quo = {o.quo[QW-2:0], 1'b0};
      if (o.rem >= (F+1)'(o.d)) begin
        o.rem    = o.rem - (F+1)'(o.d);
        o.quo[0] = 1'b1;
      end
    end
    return o;
  endfunction

  // Item state and valid bits travel alongside the arithmetic.
  item_t            car [DEPTH-1];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      car[0] <= in_item;
      for (int j = 1; j < DEPTH - 1; j++) begin
        car[j] <= car[j-1];
      end
    end
  end

  assign out_valid = vld[DEPTH-1];

  // x / 3 by reciprocal with one correction.
  logic [55:0]         prod3;
  logic [RADIUS_W-1:0] q3e;
  logic [RADIUS_W-1:0] rem3;
  logic [RADIUS_W-1:0] v [2];

  assign q3e  = prod3[55:32];
  assign rem3 = car[0].x - RADIUS_W'(q3e + (q3e << 1));

  always_ff @(posedge clk) begin
    if (ce) begin
      prod3 <= 56'(in_item.x) * 56'(RECIP3);
      v[0]  <= car[0].x;
      v[1]  <= (rem3 >= RADIUS_W'(3)) ? q3e + RADIUS_W'(1) : q3e;
    end
  end

  logic [F:0] e_val [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [40:0]         nprod;
    logic [RADIUS_W-1:0] v3;
    logic [RADIUS_W-1:0] v4;
    logic [8:0]          nest4;
    logic [40:0]         m4;
    logic [32:0]         r5;
    logic [8:0]          n5;
    logic [31:0]         term_s [TAYLOR_TERMS];
    acc_t                acc_s  [TAYLOR_TERMS];
    acc_t                acc_e1;
    acc_t                acc_fin;
    logic [33:0]         diff2;
    logic [5:0]          n2;
    logic [33:0]         shifted;

    // Range reduction v = n*ln2 + r; the estimate of n is low by at most one.
    always_ff @(posedge clk) begin
      if (ce) begin
        nprod <= 41'(v[l]) * 41'(RECIP_LN2);
        v3    <= v[l];
        nest4 <= nprod[40:32];
        m4    <= 41'(nprod[40:32]) * 41'(LN2_Q32);
        v4    <= v3;
        r5    <= 33'(41'({v4, 16'd0}) - m4);
        n5    <= nest4;
        if (r5 >= 33'(LN2_Q32)) begin
          term_s[0] <= 32'(r5 - 33'(LN2_Q32));
          acc_s[0]  <= '{r: 32'(r5 - 33'(LN2_Q32)), n: n5 + 9'd1,
                         pos: 34'd1 << 32, neg: 34'd0};
        end else begin
          term_s[0] <= r5[31:0];
          acc_s[0]  <= '{r: r5[31:0], n: n5, pos: 34'd1 << 32, neg: 34'd0};
        end
      end
    end

    // One Taylor term per block: multiply by r, then divide by k.
    for (genvar b = 0; b < TAYLOR_TERMS - 1; b++) begin : g_term
      localparam int          K       = b + 2;
      localparam logic [31:0] RECIP_K = 32'((64'd1 << 32) / K);
      logic [63:0] mul1;
      acc_t        acc_add;
      acc_t        a1, a2, a3;
      logic [31:0] p1, p2, qe3, rm3;
      logic [63:0] pm2;
      logic [31:0] qe;

      assign mul1 = 64'(term_s[b]) * 64'(acc_s[b].r);
      assign qe   = pm2[63:32];

      // The previous term joins its sum here.
      always_comb begin
        acc_add = acc_s[b];
        if (((K - 1) % 2) == 1) begin
          acc_add.neg = acc_s[b].neg + 34'(term_s[b]);
        end else begin
          acc_add.pos = acc_s[b].pos + 34'(term_s[b]);
        end
      end

      always_ff @(posedge clk) begin
        if (ce) begin
          p1            <= mul1[63:32];
          a1            <= acc_add;
          pm2           <= 64'(p1) * 64'(RECIP_K);
          p2            <= p1;
          a2            <= a1;
          qe3           <= qe;
          rm3           <= p2 - 32'(64'(qe) * 64'(K));
          a3            <= a2;
          term_s[b+1]   <= (rm3 >= 32'(K)) ? qe3 + 32'd1 : qe3;
          acc_s[b+1]    <= a3;
        end
      end
    end

    always_comb begin
      acc_fin = acc_s[TAYLOR_TERMS-1];
      if ((TAYLOR_TERMS % 2) == 1) begin
        acc_fin.neg = acc_s[TAYLOR_TERMS-1].neg + 34'(term_s[TAYLOR_TERMS-1]);
      end else begin
        acc_fin.pos = acc_s[TAYLOR_TERMS-1].pos + 34'(term_s[TAYLOR_TERMS-1]);
      end
    end

    assign shifted = diff2 >> (6'(n2) + 6'(32 - F));

    always_ff @(posedge clk) begin
      if (ce) begin
        acc_e1 <= acc_fin;
        if (acc_e1.n > 9'd32 || acc_e1.neg >= acc_e1.pos) begin
          diff2 <= '0;
        end else begin
          diff2 <= acc_e1.pos - acc_e1.neg;
        end
        n2       <= acc_e1.n[5:0];
        e_val[l] <= shifted[F:0];
      end
    end
  end

  // Residual, derivative and the start of the step division.
  logic [F+2:0] g_sum;
  logic [F+1:0] d_sum;
  logic [F+1:0] fval;
  logic         fneg;
  logic [F:0]   mag;
  div_t         dv [DIV_STAGES+1];

  assign g_sum = (F+3)'(e_val[0]) + (F+3)'(e_val[1]) + ((F+3)'(e_val[1]) << 1);
  assign d_sum = (F+2)'(e_val[0]) + (F+2)'(e_val[1]);
  assign fval  = ((F+2)'(1) << F) - (F+2)'(g_sum[F+2:2]) - (F+2)'(car[E4J-2].xi);
  assign fneg  = fval[F+1];
  assign mag   = fneg ? (F+1)'(-fval) : fval[F:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      dv[0].num  <= QW'(mag) << 16;
      dv[0].quo  <= '0;
      dv[0].rem  <= '0;
      dv[0].d    <= d_sum[F+1:2];
      dv[0].fneg <= fneg;
      dv[0].dz   <= (d_sum[F+1:2] == '0);
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (ce) begin
        dv[s+1] <= div_next(dv[s]);
      end
    end
  end

  // Apply the step with the clamps at zero and at the maximum.
  logic [RADIUS_W-1:0] x_cur;
  logic [QW:0]         x_sum;

  assign x_cur = car[DEPTH-2].x;
  assign x_sum = (QW+1)'(x_cur) + (QW+1)'(dv[DIV_STAGES].quo);

  always_ff @(posedge clk) begin
    if (ce) begin
      out_item.xi <= car[DEPTH-2].xi;
      if (dv[DIV_STAGES].dz) begin
        out_item.x    <= x_cur;
        out_item.flag <= 1'b1;
      end else if (!dv[DIV_STAGES].fneg) begin
        out_item.flag <= car[DEPTH-2].flag;
        if (QW'(x_cur) > dv[DIV_STAGES].quo) begin
          out_item.x <= x_cur - dv[DIV_STAGES].quo[RADIUS_W-1:0];
        end else begin
          out_item.x <= '0;
        end
      end else if (x_sum > (QW+1)'(RADIUS_MAX)) begin
        out_item.x    <= RADIUS_MAX;
        out_item.flag <= 1'b1;
      end else begin
        out_item.x    <= x_sum[RADIUS_W-1:0];
        out_item.flag <= car[DEPTH-2].flag;
      end
    end
  end

endmodule

// ===== rtl/core/diffusion_inverse_cdf_newton.sv =====
// Channel   Direction  Contents
// s_axis    in         tdata: probability Q0.16 [15:0], start_guess Q8.16 [39:16]
// m_axis    out        tdata: radius Q8.16 [23:0]; tuser: saturated [0]
//
// One item enters per cycle while m_axis is not stalled; each item passes through NEWTON_STEPS Newton steps.
// Each Newton step is 68 stages, set by the thirteen-term exponential series
// (four stages a term) and the radix-16 step division.
// rst is synchronous and clears the valid bits only.
// A stall at m_axis freezes the whole pipeline; s_axis_tready drops with it.
module diffusion_inverse_cdf_newton (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // probability [15:0], start_guess [39:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // radius [23:0]
  output logic        m_axis_tuser    // saturated [0]
);
  import dicn_pkg::*;

  logic                     ce;
  logic [PROB_W-1:0]        probability;
  logic [FRACTION_BITS-1:0] xi_f;
  item_t                    st_item  [NEWTON_STEPS+1];
  logic                     st_valid [NEWTON_STEPS+1];

  assign probability = s_axis_tdata[PROB_W-1:0];

  if (FRACTION_BITS >= PROB_W) begin : g_xi_up
    assign xi_f = FRACTION_BITS'(probability) << (FRACTION_BITS - PROB_W);
  end else begin : g_xi_down
    assign xi_f = FRACTION_BITS'(probability >> (PROB_W - FRACTION_BITS));
  end

  assign ce            = !st_valid[NEWTON_STEPS] || m_axis_tready;
  assign s_axis_tready = ce;

  assign st_valid[0]     = s_axis_tvalid;
  assign st_item[0].x    = s_axis_tdata[PROB_W +: RADIUS_W];
  assign st_item[0].xi   = xi_f;
  assign st_item[0].flag = 1'b0;

  for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_step
    dicn_step u_step (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .in_valid  (st_valid[i]),
      .in_item   (st_item[i]),
      .out_valid (st_valid[i+1]),
      .out_item  (st_item[i+1])
    );
  end

  assign m_axis_tvalid = st_valid[NEWTON_STEPS];
  assign m_axis_tdata  = st_item[NEWTON_STEPS].x;
  assign m_axis_tuser  = st_item[NEWTON_STEPS].flag;

endmodule

// ===== rtl/core/dicn_checker.sv =====
`include "assert_macros.svh"

module dicn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A waiting result item stays put until it is taken.
  `ASSERT_CLK(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result item changed while stalled")

  // The input side stalls exactly when a result item is stuck at the output.
  `ASSERT_CLK(a_ready, clk, rst, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output stall")

  // Reset empties the pipeline.
  `ASSERT_CLK_ALWAYS(a_reset, clk, rst |=> !m_axis_tvalid, "result item right after reset")

endmodule

bind diffusion_inverse_cdf_newton dicn_checker u_dicn_checker (.*);
